/* hdl/auth_failure_lockout_table_macros.svh */
// Assertion macros shared by the lockout table RTL.
`ifndef AUTH_FAILURE_LOCKOUT_TABLE_MACROS_SVH
`define AUTH_FAILURE_LOCKOUT_TABLE_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define AFL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lockout table check failed");
// Next-cycle implication, checked outside reset.
`define AFL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lockout table check failed");
`endif

/* hdl/afl_pkg.sv */
// Types and constants of the lockout table.
package afl_pkg;
   localparam logic [1:0] CMD_CHECK   = 2'd0;
   localparam logic [1:0] CMD_FAILURE = 2'd1;
   localparam logic [1:0] CMD_SUCCESS = 2'd2;

   localparam logic [1:0] CSR_FAILURE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [1:0] CSR_BLOCK_LENGTH  = 2'd2;

   localparam logic [3:0]  FAILURE_LIMIT_RESET = 4'd8;
   localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd60000;
   localparam logic [31:0] BLOCK_LENGTH_RESET  = 32'd60000;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] peer_address;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic allowed;
      logic newly_blocked;
      logic evicted;
   } rsp_type;
endpackage

/* hdl/afl_cell.sv */
// One table entry of the rotating chain.
module afl_cell #(
   parameter int DATA_BITS = 180
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  logic                 valid_in,
   input  logic [DATA_BITS-1:0] data_in,
   output logic                 valid_out,
   output logic [DATA_BITS-1:0] data_out
);
   logic                 valid_ff;
   logic [DATA_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule

/* hdl/auth_failure_lockout_table.sv */
// The result strobe rises once the search turn, the ST_CALC update and the write-back turn are done.
// Entries rotate through a ring of cells, one per cycle while the ring shifts (ST_SCAN, ST_APPLY):
// one full turn searches, ST_CALC computes the update, a second full turn writes it back in place.
// A new item is taken only when idle, after the last one is through; busy falls in the strobe cycle.
// Synchronous reset empties the table and loads the register defaults.
// Results come as a one-cycle beat on rsp_valid; the receiver cannot stall.
module auth_failure_lockout_table #(
   parameter int TABLE_ENTRIES = 256,
   parameter int TIME_BITS     = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  afl_pkg::req_type  req_data,
   output logic              rsp_valid,
   output afl_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import afl_pkg::*;
`include "auth_failure_lockout_table_macros.svh"

   localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);
   localparam int DATA_BITS = 32 + 4 + 3 * TIME_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_CALC  = 2'd2;
   localparam logic [1:0] ST_APPLY = 2'd3;

   // Config registers.
   logic [3:0]  limit_ff;
   logic [31:0] window_ff, block_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= FAILURE_LIMIT_RESET;
         window_ff <= WINDOW_LENGTH_RESET;
         block_ff  <= BLOCK_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FAILURE_LIMIT: limit_ff  <= csr_data[3:0];
            CSR_WINDOW_LENGTH: window_ff <= csr_data;
            CSR_BLOCK_LENGTH:  block_ff  <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = !busy;

   // Cell chain.
   logic                 cell_valid [TABLE_ENTRIES];
   logic [DATA_BITS-1:0] cell_data  [TABLE_ENTRIES];
   logic                 head_valid;
   logic [DATA_BITS-1:0] head_data;
   logic                 shift_en;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      if (i == TABLE_ENTRIES - 1) begin : g_tail
         afl_cell #(.DATA_BITS(DATA_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift_en(shift_en),
            .valid_in(head_valid), .data_in(head_data),
            .valid_out(cell_valid[i]), .data_out(cell_data[i]));
      end else begin : g_body
         afl_cell #(.DATA_BITS(DATA_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift_en(shift_en),
            .valid_in(cell_valid[i+1]), .data_in(cell_data[i+1]),
            .valid_out(cell_valid[i]), .data_out(cell_data[i]));
      end
   end

   // Fields of the entry at the head of the ring.
   logic [31:0]          h_key;
   logic [3:0]           h_count;
   logic [TIME_BITS-1:0] h_ws, h_bu, h_ls;
   assign {h_key, h_count, h_ws, h_bu, h_ls} = cell_data[0];

   // Control and item registers.
   logic [1:0]           state_ff, state_in;
   logic [IDX_BITS-1:0]  idx_ff;
   logic [1:0]           cmd_ff;
   logic [31:0]          key_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 hit_ff, free_ff, stale_ff;
   logic [IDX_BITS-1:0]  hit_idx_ff, free_idx_ff, stale_idx_ff, target_ff;
   logic [3:0]           m_count_ff;
   logic [TIME_BITS-1:0] m_ws_ff, m_bu_ff;
   logic                 wr_en_ff, wr_valid_ff;
   logic [DATA_BITS-1:0] wr_data_ff;
   logic                 res_allowed_ff, res_newly_ff, res_evict_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 head_hit, head_stale;
   assign head_hit   = cell_valid[0] && (h_key == key_ff);
   assign head_stale = ((now_ff - h_ls) > TIME_BITS'(window_ff));

   assign busy     = (state_ff != ST_IDLE);
   assign shift_en = (state_ff == ST_SCAN) || (state_ff == ST_APPLY);

   always_comb begin
      head_valid = cell_valid[0];
      head_data  = cell_data[0];
      if ((state_ff == ST_APPLY) && wr_en_ff && (idx_ff == target_ff)) begin
         head_valid = wr_valid_ff;
         head_data  = wr_data_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SCAN;
         ST_SCAN:  if (idx_ff == LAST_IDX) state_in = ST_CALC;
         ST_CALC:  state_in = ST_APPLY;
         ST_APPLY: if (idx_ff == LAST_IDX) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (shift_en) begin
            idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         end else begin
            idx_ff <= '0;
         end
      end
   end

   // Search over one turn of the ring.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         cmd_ff   <= req_data.command;
         key_ff   <= req_data.peer_address;
         now_ff   <= TIME_BITS'(req_data.now_ms);
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         stale_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (head_hit && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
            m_count_ff <= h_count;
            m_ws_ff    <= h_ws;
            m_bu_ff    <= h_bu;
         end
         if (!cell_valid[0] && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (head_stale && !stale_ff) begin
            stale_ff     <= 1'b1;
            stale_idx_ff <= idx_ff;
         end
      end
   end

   // Update of the selected entry.
   logic                   c_renew;
   logic [3:0]             c_base_cnt, c_cnt;
   logic [TIME_BITS-1:0]   c_ws, c_bu, c_sat;
   logic [TIME_BITS:0]     c_sum;
   logic                   c_block;

   always_comb begin
      c_renew    = (now_ff - m_ws_ff) > TIME_BITS'(window_ff);
      c_sum      = {1'b0, now_ff} + (TIME_BITS+1)'(block_ff);
      c_sat      = c_sum[TIME_BITS] ? '1 : c_sum[TIME_BITS-1:0];
      c_base_cnt = m_count_ff;
      c_ws       = m_ws_ff;
      c_bu       = m_bu_ff;
      if (!hit_ff) begin
         c_base_cnt = '0;
         c_ws       = now_ff;
         c_bu       = '0;
      end else if (c_renew) begin
         c_base_cnt = '0;
         c_ws       = now_ff;
      end
      c_cnt   = c_base_cnt + 4'd1;
      c_block = (c_cnt >= limit_ff);
      if (c_block) begin
         c_cnt = '0;
         c_ws  = now_ff;
         c_bu  = c_sat;
      end
   end

   logic                 wr_en_in, wr_valid_in;
   logic [DATA_BITS-1:0] wr_data_in;
   logic [IDX_BITS-1:0]  target_in;
   logic                 res_allowed_in, res_newly_in, res_evict_in;

   always_comb begin
      wr_en_in       = 1'b0;
      wr_valid_in    = 1'b1;
      wr_data_in     = {key_ff, m_count_ff, m_ws_ff, m_bu_ff, now_ff};
      target_in      = hit_idx_ff;
      res_allowed_in = 1'b0;
      res_newly_in   = 1'b0;
      res_evict_in   = 1'b0;
      unique case (cmd_ff)
         CMD_CHECK: begin
            res_allowed_in = !hit_ff || (now_ff >= m_bu_ff);
            wr_en_in       = hit_ff;
         end
         CMD_FAILURE: begin
            wr_en_in     = 1'b1;
            wr_data_in   = {key_ff, c_cnt, c_ws, c_bu, now_ff};
            res_newly_in = c_block;
            res_evict_in = !hit_ff && !free_ff;
            if (!hit_ff) begin
               target_in = free_ff ? free_idx_ff : (stale_ff ? stale_idx_ff : '0);
            end
         end
         CMD_SUCCESS: begin
            wr_en_in    = hit_ff;
            wr_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         wr_en_ff       <= wr_en_in;
         wr_valid_ff    <= wr_valid_in;
         wr_data_ff     <= wr_data_in;
         target_ff      <= target_in;
         res_allowed_ff <= res_allowed_in;
         res_newly_ff   <= res_newly_in;
         res_evict_ff   <= res_evict_in;
      end
   end

   // Result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else if (state_ff == ST_APPLY && idx_ff == LAST_IDX) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= '{allowed: res_allowed_ff, newly_blocked: res_newly_ff,
                           evicted: res_evict_ff};
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AFL_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `AFL_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy) && !busy)
   `AFL_ASSERT_NOW(a_rsp_quiet, clock, reset, !rsp_valid, rsp_data == '0)
   `AFL_ASSERT_NOW(a_rsp_exclusive, clock, reset, rsp_valid,
                   !(rsp_data.allowed && (rsp_data.newly_blocked || rsp_data.evicted)))
endmodule
